@@ sv/slc_pkg.sv @@
package slc_pkg;

  localparam logic [7:0] CH_S    = 8'h53;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_UA   = 8'h41;
  localparam logic [7:0] CH_UF   = 8'h46;
  localparam logic [7:0] IDX_MAX = 8'd255;
  localparam logic [7:0] SUM_OK  = 8'hFF;
  localparam logic [3:0] TYPE_S5 = 4'd5;
  localparam logic [3:0] HEX_ALPHA_OFS = 4'd9;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_NOS   = 3'd1,
    ST_TYPE  = 3'd2,
    ST_HEX   = 3'd3,
    ST_COUNT = 3'd4,
    ST_SUM   = 3'd5,
    ST_LINES = 3'd6,
    ST_TERM  = 3'd7
  } status_t;

  typedef struct packed {
    logic [7:0]  char_code;
    logic        end_of_line;
    logic [15:0] expected_count;
    logic        check_end;
    logic [3:0]  expected_end_type;
  } in_item_t;

  typedef struct packed {
    status_t    status;
    logic [3:0] record_type;
    logic [7:0] byte_count;
  } out_item_t;

  // Line summary handed from the character front end to the finisher.
  typedef struct packed {
    status_t     first_error;
    logic [7:0]  len;
    logic [3:0]  line_type;
    logic [7:0]  count_field;
    logic [7:0]  pair_sum;
    logic [15:0] address_word;
    logic [15:0] expected_count;
    logic        check_end;
    logic [3:0]  expected_end_type;
  } line_sum_t;

endpackage

@@ sv/srecord_line_checker.sv @@
// S-record line checker.
// Input channel (char_valid/char_ready/char_item): one ASCII character of a
// record line per item; end_of_line marks the last one. expected_count,
// check_end and expected_end_type are only looked at on that last item.
// Output channel (result_valid/result_ready/result_item): one item per line,
// carrying the status (first failing check), the type digit and byte count.
// Characters that do not end a line produce nothing.
// Throughput: one character per cycle while the summary queue has room. The
// character front end registers its running line state (pair sum, count
// field, address word) as each character is taken. A line-end character's
// summary is written to the summary queue, then the registered final check
// takes it into the output register.
// A 4-entry summary queue sits between the front end and the finisher, so
// a stalled receiver only blocks input once the queue holds four line
// summaries behind the one in the output register; until then characters
// keep flowing. Non-final characters are never held back except by a full
// queue.
// Reset (rst, synchronous): clears the line state, empties the queue and
// drops result_valid. The first character after reset starts a new line.
module srecord_line_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               char_valid,
  output logic               char_ready,
  input  slc_pkg::in_item_t  char_item,
  output logic               result_valid,
  input  logic               result_ready,
  output slc_pkg::out_item_t result_item
);
  import slc_pkg::*;

  logic      push, push_ready;
  line_sum_t push_item;
  logic      q_valid, q_pop;
  line_sum_t q_item;

  // character decode and running line state
  slc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_item  (char_item),
    .push       (push),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // decouples line ends from the output handshake
  slc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_item   (q_item)
  );

  // end-of-line checks and output register
  slc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_item       (q_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
  );

  // a line end taken in always lands in the queue
  a_eol_queued: assert property (@(posedge clk) disable iff (rst)
    char_valid && char_ready && char_item.end_of_line |=> q_valid)
    else $error("line end lost before queue");

  // no result appears without a queued line summary
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    !q_valid && !(result_valid && !result_ready) |=> !result_valid)
    else $error("result without line summary");

  // the type digit is always decimal
  a_type_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result_item.record_type <= 4'd9)
    else $error("record type out of range");

endmodule

@@ sv/slc_front.sv @@
module slc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              char_valid,
  output logic              char_ready,
  input  slc_pkg::in_item_t char_item,
  output logic              push,
  input  logic              push_ready,
  output slc_pkg::line_sum_t push_item
);
  import slc_pkg::*;

  logic [7:0]  char_index, char_index_next;
  logic [3:0]  line_type, line_type_next;
  logic [7:0]  count_field, count_field_next;
  logic [7:0]  pair_sum, pair_sum_next;
  logic [3:0]  high_nibble, high_nibble_next;
  logic [15:0] address_word, address_word_next;
  status_t     first_error, first_error_next;

  logic [7:0] c;
  logic       is_dig, is_alpha;
  logic [3:0] nib;
  status_t    err;
  logic       take;

  assign char_ready = push_ready;
  assign take       = char_valid && char_ready;
  assign c          = char_item.char_code;
  assign is_dig     = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_alpha   = (c >= CH_UA) && (c <= CH_UF);
  // 'A'..'F' have low nibble 1..6, value is that plus 9
  assign nib = is_dig ? c[3:0] : (is_alpha ? c[3:0] + HEX_ALPHA_OFS : 4'd0);

  always_comb begin
    err               = ST_OK;
    line_type_next    = line_type;
    count_field_next  = count_field;
    pair_sum_next     = pair_sum;
    high_nibble_next  = high_nibble;
    address_word_next = address_word;

    if (char_index == 8'd0) begin
      if (c != CH_S) err = ST_NOS;
    end else if (char_index == 8'd1) begin
      if (is_dig) line_type_next = c[3:0];
      else err = ST_TYPE;
    end else if (!(is_dig || is_alpha)) begin
      err = ST_HEX;
    end

    first_error_next = (first_error == ST_OK) ? err : first_error;

    if (char_index >= 8'd2 && char_index < IDX_MAX) begin
      if (!char_index[0]) high_nibble_next = nib;
      else pair_sum_next = pair_sum + {high_nibble, nib};
      if (char_index == 8'd2) count_field_next = {nib, 4'd0};
      else if (char_index == 8'd3) count_field_next = {count_field[7:4], nib};
      if (char_index >= 8'd4 && char_index <= 8'd7) begin
        case (char_index[1:0])
          2'd0:    address_word_next[15:12] = nib;
          2'd1:    address_word_next[11:8]  = nib;
          2'd2:    address_word_next[7:4]   = nib;
          default: address_word_next[3:0]   = nib;
        endcase
      end
    end

    char_index_next = (char_index < IDX_MAX) ? char_index + 8'd1 : char_index;
  end

  assign push = take && char_item.end_of_line;

  always_comb begin
    push_item.first_error       = first_error_next;
    push_item.len               = char_index_next;
    push_item.line_type         = line_type_next;
    push_item.count_field       = count_field_next;
    push_item.pair_sum          = pair_sum_next;
    push_item.address_word      = address_word_next;
    push_item.expected_count    = char_item.expected_count;
    push_item.check_end         = char_item.check_end;
    push_item.expected_end_type = char_item.expected_end_type;
  end

  always_ff @(posedge clk) begin
    if (rst || push) begin
      char_index   <= '0;
      line_type    <= '0;
      count_field  <= '0;
      pair_sum     <= '0;
      high_nibble  <= '0;
      address_word <= '0;
      first_error  <= ST_OK;
    end else if (take) begin
      char_index   <= char_index_next;
      line_type    <= line_type_next;
      count_field  <= count_field_next;
      pair_sum     <= pair_sum_next;
      high_nibble  <= high_nibble_next;
      address_word <= address_word_next;
      first_error  <= first_error_next;
    end
  end

endmodule

@@ sv/slc_queue.sv @@
module slc_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               push_ready,
  input  slc_pkg::line_sum_t push_item,
  output logic               pop_valid,
  input  logic               pop,
  output slc_pkg::line_sum_t pop_item
);
  import slc_pkg::*;

  line_sum_t      entries [QDEPTH];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic [QAW:0]   fill;
  logic           do_push, do_pop;

  assign push_ready = (fill != (QAW+1)'(QDEPTH));
  assign pop_valid  = (fill != '0);
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_item   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) fill <= fill + 1'b1;
      else if (do_pop && !do_push) fill <= fill - 1'b1;
    end
  end

endmodule

@@ sv/slc_back.sv @@
module slc_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_pop,
  input  slc_pkg::line_sum_t  q_item,
  output logic                result_valid,
  input  logic                result_ready,
  output slc_pkg::out_item_t  result_item
);
  import slc_pkg::*;

  status_t    st;
  logic [7:0] len;
  logic [7:0] half_body;
  out_item_t  res_next;

  assign len       = q_item.len;
  assign half_body = (len - 8'd4) >> 1;
  assign q_pop     = q_valid && (!result_valid || result_ready);

  always_comb begin
    st = q_item.first_error;
    if (st == ST_OK && len < 8'd2) st = ST_TYPE;
    if (st == ST_OK) begin
      if (len < 8'd4 || len[0] || len >= IDX_MAX) st = ST_COUNT;
      else if (q_item.count_field != half_body) st = ST_COUNT;
    end
    if (st == ST_OK && q_item.pair_sum != SUM_OK) st = ST_SUM;
    if (st == ST_OK && q_item.line_type == TYPE_S5 &&
        q_item.address_word != q_item.expected_count) st = ST_LINES;
    if (st == ST_OK && q_item.check_end &&
        q_item.line_type != q_item.expected_end_type) st = ST_TERM;
    res_next.status      = st;
    res_next.record_type = q_item.line_type;
    res_next.byte_count  = q_item.count_field;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (q_pop) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) result_item <= res_next;
  end

endmodule
